>>> hdl/sgi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared types, codes and constants of the segment intersection block.
// ----------------------------------------------------------------------------
package sgi_pkg;

    localparam int IN_W           = 16;
    localparam int OUT_W          = 48;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_MAX      = 24;   // widest supported coordinate

    localparam logic [1:0] ST_PARALLEL = 2'd0;
    localparam logic [1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [1:0] ST_WITHIN   = 2'd2;

    typedef struct packed {
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] bx;
        logic signed [IN_W-1:0] by_coord;
        logic signed [IN_W-1:0] cx;
        logic signed [IN_W-1:0] cy;
        logic signed [IN_W-1:0] dx;
        logic signed [IN_W-1:0] dy;
    } sgi_in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [OUT_W-1:0] x_out;
        logic signed [OUT_W-1:0] y_out;
        logic                    saturated;
    } sgi_out_t;

    // Sideband that rides along the divider stages
    typedef struct packed {
        logic signed [COORD_MAX-1:0] ax;
        logic signed [COORD_MAX-1:0] ay;
        logic                        neg_x;
        logic                        neg_y;
        logic                        is_par;
        logic                        on_both;
    } sgi_side_t;

endpackage

>>> hdl/segment_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection
// Intersection point of two segments in signed Q32.16 with an exact
// within-both-segments test, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat
//  --------+-------------------------------+----------------------------------
//  input   | s_valid, s_ready, s_payload   | segment pair AB, CD (sgi_in_t)
//  output  | m_valid, m_ready, m_payload   | status, x, y, saturated (sgi_out_t)
//
//  One beat per cycle in and out while m_ready does not stall. The pipe has
//  five front stages, one restoring-divider stage per quotient bit and one
//  output stage. The divider length sets the latency.
//  Synchronous active-low reset clears the valid bits only.
//  A stall on m_ready freezes the whole pipe; s_ready follows it.
// ----------------------------------------------------------------------------
module segment_intersection #(
    parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sgi_pkg::sgi_in_t   s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output sgi_pkg::sgi_out_t  m_payload
);
    import sgi_pkg::*;

    localparam int TW = 2 * COORD_BITS + 3;
    localparam int NW = 3 * COORD_BITS + 4 + FRAC_BITS;

    logic          en;
    logic          v      [0:NW];
    sgi_side_t     side   [0:NW];
    logic [NW-1:0] dvd_x  [0:NW];
    logic [NW-1:0] dvd_y  [0:NW];
    logic [TW-1:0] rem_x  [0:NW];
    logic [TW-1:0] rem_y  [0:NW];
    logic [TW-1:0] dvsr   [0:NW];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    sgi_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_payload),
        .out_valid (v[0]),
        .out_side  (side[0]),
        .out_dvd_x (dvd_x[0]),
        .out_dvd_y (dvd_y[0]),
        .out_div   (dvsr[0])
    );

    assign rem_x[0] = '0;
    assign rem_y[0] = '0;

    for (genvar i = 0; i < NW; i++) begin : g_div
        sgi_div_stage #(
            .NW (NW),
            .DW (TW)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v[i]),
            .in_side   (side[i]),
            .in_dvd_x  (dvd_x[i]),
            .in_dvd_y  (dvd_y[i]),
            .in_rem_x  (rem_x[i]),
            .in_rem_y  (rem_y[i]),
            .in_div    (dvsr[i]),
            .out_valid (v[i+1]),
            .out_side  (side[i+1]),
            .out_dvd_x (dvd_x[i+1]),
            .out_dvd_y (dvd_y[i+1]),
            .out_rem_x (rem_x[i+1]),
            .out_rem_y (rem_y[i+1]),
            .out_div   (dvsr[i+1])
        );
    end

    sgi_back #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW),
        .DW        (TW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v[NW]),
        .in_side   (side[NW]),
        .in_q_x    (dvd_x[NW]),
        .in_q_y    (dvd_y[NW]),
        .in_rem_x  (rem_x[NW]),
        .in_rem_y  (rem_y[NW]),
        .out_valid (m_valid),
        .out_data  (m_payload)
    );

`ifndef ASSERT_OFF
    localparam logic signed [OUT_W-1:0] OMAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OMIN = {1'b1, {(OUT_W-1){1'b0}}};

    a_par_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == ST_PARALLEL) |->
            (m_payload.x_out == '0) && (m_payload.y_out == '0) && !m_payload.saturated)
        else $error("parallel beat with nonzero point");

    a_sat_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.saturated |->
            (m_payload.x_out == OMAX) || (m_payload.x_out == OMIN) ||
            (m_payload.y_out == OMAX) || (m_payload.y_out == OMIN))
        else $error("saturated flag without a clamped coordinate");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no output beat pending");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status == ST_PARALLEL) ||
            (m_payload.status == ST_OUTSIDE) || (m_payload.status == ST_WITHIN))
        else $error("illegal status code");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("output beat changed while stalled");
`endif

endmodule

>>> hdl/sgi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_front
// Five stages: differences, cross products, det/tn/un, magnitudes and signs,
// numerator products plus the within test.
// ----------------------------------------------------------------------------
module sgi_front #(
    parameter  int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
    parameter  int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF,
    localparam int TW         = 2 * COORD_BITS + 3,
    localparam int PW         = 3 * COORD_BITS + 4,
    localparam int NW         = PW + FRAC_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  sgi_pkg::sgi_in_t    in_data,
    output logic                out_valid,
    output sgi_pkg::sgi_side_t  out_side,
    output logic [NW-1:0]       out_dvd_x,
    output logic [NW-1:0]       out_dvd_y,
    output logic [TW-1:0]       out_div
);
    import sgi_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int LOWB = (C < IN_W) ? C : IN_W;
    localparam int MW   = 2 * C + 2;

    // Wide coordinates take the 16 input bits unsigned
    function automatic logic signed [C-1:0] ext(input logic [IN_W-1:0] v);
        if (C > IN_W) begin
            return C'(v);
        end else begin
            return C'($signed(v[LOWB-1:0]));
        end
    endfunction

    logic signed [C-1:0] e_ax, e_ay, e_bx, e_by, e_cx, e_cy, e_dx, e_dy;

    assign e_ax = ext(in_data.ax);
    assign e_ay = ext(in_data.ay);
    assign e_bx = ext(in_data.bx);
    assign e_by = ext(in_data.by_coord);
    assign e_cx = ext(in_data.cx);
    assign e_cy = ext(in_data.cy);
    assign e_dx = ext(in_data.dx);
    assign e_dy = ext(in_data.dy);

    // stage 1
    logic                v1_reg;
    logic signed [C:0]   rx1_reg, ry1_reg, sx1_reg, sy1_reg, qx1_reg, qy1_reg;
    logic signed [C-1:0] ax1_reg, ay1_reg;
    logic signed [C:0]   rx1_next, ry1_next, sx1_next, sy1_next, qx1_next, qy1_next;

    assign rx1_next = e_bx - e_ax;
    assign ry1_next = e_by - e_ay;
    assign sx1_next = e_dx - e_cx;
    assign sy1_next = e_dy - e_cy;
    assign qx1_next = e_cx - e_ax;
    assign qy1_next = e_cy - e_ay;

    // stage 2
    logic                 v2_reg;
    logic signed [MW-1:0] pd1_reg, pd2_reg, pt1_reg, pt2_reg, pu1_reg, pu2_reg;
    logic signed [C:0]    rx2_reg, ry2_reg;
    logic signed [C-1:0]  ax2_reg, ay2_reg;
    logic signed [MW-1:0] pd1_next, pd2_next, pt1_next, pt2_next, pu1_next, pu2_next;

    assign pd1_next = rx1_reg * sy1_reg;
    assign pd2_next = ry1_reg * sx1_reg;
    assign pt1_next = qx1_reg * sy1_reg;
    assign pt2_next = qy1_reg * sx1_reg;
    assign pu1_next = qx1_reg * ry1_reg;
    assign pu2_next = qy1_reg * rx1_reg;

    // stage 3
    logic                 v3_reg;
    logic signed [TW-1:0] det3_reg, tn3_reg, un3_reg;
    logic signed [C:0]    rx3_reg, ry3_reg;
    logic signed [C-1:0]  ax3_reg, ay3_reg;
    logic signed [TW-1:0] det3_next, tn3_next, un3_next;

    assign det3_next = pd1_reg - pd2_reg;
    assign tn3_next  = pt1_reg - pt2_reg;
    assign un3_next  = pu1_reg - pu2_reg;

    // stage 4
    logic                v4_reg, negx4_reg, negy4_reg, par4_reg;
    logic [C:0]          mrx4_reg, mry4_reg;
    logic [TW-1:0]       mtn4_reg, mdet4_reg;
    logic signed [TW:0]  tnn4_reg, unn4_reg;
    logic signed [C-1:0] ax4_reg, ay4_reg;
    logic [C:0]          mrx4_next, mry4_next;
    logic [TW-1:0]       mtn4_next, mdet4_next;
    logic signed [TW:0]  tn_w, un_w, tnn4_next, unn4_next;
    logic                dneg, tneg;

    assign dneg       = det3_reg[TW-1];
    assign tneg       = tn3_reg[TW-1];
    assign mrx4_next  = rx3_reg[C] ? $unsigned(-rx3_reg) : $unsigned(rx3_reg);
    assign mry4_next  = ry3_reg[C] ? $unsigned(-ry3_reg) : $unsigned(ry3_reg);
    assign mtn4_next  = tneg ? $unsigned(-tn3_reg) : $unsigned(tn3_reg);
    assign mdet4_next = dneg ? $unsigned(-det3_reg) : $unsigned(det3_reg);
    assign tn_w       = tn3_reg;
    assign un_w       = un3_reg;
    // fold the det sign into tn and un so the range test sees det > 0
    assign tnn4_next  = dneg ? -tn_w : tn_w;
    assign unn4_next  = dneg ? -un_w : un_w;

    // stage 5
    logic                 v5_reg;
    sgi_side_t            side5_reg;
    logic [NW-1:0]        dvdx5_reg, dvdy5_reg;
    logic [TW-1:0]        div5_reg;
    logic [PW-1:0]        prx, pry;
    logic signed [TW:0]   dsn;
    logic                 on_both5;

    assign prx      = mrx4_reg * mtn4_reg;
    assign pry      = mry4_reg * mtn4_reg;
    assign dsn      = $signed({1'b0, mdet4_reg});
    assign on_both5 = (tnn4_reg >= 0) && (tnn4_reg <= dsn)
                   && (unn4_reg >= 0) && (unn4_reg <= dsn);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rx1_reg <= rx1_next;
            ry1_reg <= ry1_next;
            sx1_reg <= sx1_next;
            sy1_reg <= sy1_next;
            qx1_reg <= qx1_next;
            qy1_reg <= qy1_next;
            ax1_reg <= e_ax;
            ay1_reg <= e_ay;

            pd1_reg <= pd1_next;
            pd2_reg <= pd2_next;
            pt1_reg <= pt1_next;
            pt2_reg <= pt2_next;
            pu1_reg <= pu1_next;
            pu2_reg <= pu2_next;
            rx2_reg <= rx1_reg;
            ry2_reg <= ry1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;

            det3_reg <= det3_next;
            tn3_reg  <= tn3_next;
            un3_reg  <= un3_next;
            rx3_reg  <= rx2_reg;
            ry3_reg  <= ry2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;

            mrx4_reg  <= mrx4_next;
            mry4_reg  <= mry4_next;
            mtn4_reg  <= mtn4_next;
            mdet4_reg <= mdet4_next;
            tnn4_reg  <= tnn4_next;
            unn4_reg  <= unn4_next;
            negx4_reg <= rx3_reg[C] ^ tneg ^ dneg;
            negy4_reg <= ry3_reg[C] ^ tneg ^ dneg;
            par4_reg  <= (det3_reg == '0);
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;

            side5_reg.ax      <= ax4_reg;
            side5_reg.ay      <= ay4_reg;
            side5_reg.neg_x   <= negx4_reg;
            side5_reg.neg_y   <= negy4_reg;
            side5_reg.is_par  <= par4_reg;
            side5_reg.on_both <= on_both5;
            dvdx5_reg         <= NW'(prx) << FRAC_BITS;
            dvdy5_reg         <= NW'(pry) << FRAC_BITS;
            div5_reg          <= mdet4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_side  = side5_reg;
    assign out_dvd_x = dvdx5_reg;
    assign out_dvd_y = dvdy5_reg;
    assign out_div   = div5_reg;

endmodule

>>> hdl/sgi_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_div_stage
// One restoring step for both coordinates: one quotient bit per stage.
// Dividend shifts out the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module sgi_div_stage #(
    parameter int NW = 68,
    parameter int DW = 35
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  sgi_pkg::sgi_side_t  in_side,
    input  logic [NW-1:0]       in_dvd_x,
    input  logic [NW-1:0]       in_dvd_y,
    input  logic [DW-1:0]       in_rem_x,
    input  logic [DW-1:0]       in_rem_y,
    input  logic [DW-1:0]       in_div,
    output logic                out_valid,
    output sgi_pkg::sgi_side_t  out_side,
    output logic [NW-1:0]       out_dvd_x,
    output logic [NW-1:0]       out_dvd_y,
    output logic [DW-1:0]       out_rem_x,
    output logic [DW-1:0]       out_rem_y,
    output logic [DW-1:0]       out_div
);
    import sgi_pkg::*;

    logic [DW:0]   tx, ty, dfx, dfy, dz;
    logic          gex, gey;
    logic          valid_reg;
    sgi_side_t     side_reg;
    logic [NW-1:0] dvdx_reg, dvdy_reg;
    logic [DW-1:0] remx_reg, remy_reg, div_reg;
    logic [NW-1:0] dvdx_next, dvdy_next;
    logic [DW-1:0] remx_next, remy_next;

    assign dz  = {1'b0, in_div};
    assign tx  = {in_rem_x, in_dvd_x[NW-1]};
    assign ty  = {in_rem_y, in_dvd_y[NW-1]};
    assign gex = (tx >= dz);
    assign gey = (ty >= dz);
    assign dfx = tx - dz;
    assign dfy = ty - dz;

    assign remx_next = gex ? dfx[DW-1:0] : tx[DW-1:0];
    assign remy_next = gey ? dfy[DW-1:0] : ty[DW-1:0];
    assign dvdx_next = {in_dvd_x[NW-2:0], gex};
    assign dvdy_next = {in_dvd_y[NW-2:0], gey};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            dvdx_reg <= dvdx_next;
            dvdy_reg <= dvdy_next;
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            div_reg  <= in_div;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_dvd_x = dvdx_reg;
    assign out_dvd_y = dvdy_reg;
    assign out_rem_x = remx_reg;
    assign out_rem_y = remy_reg;
    assign out_div   = div_reg;

endmodule

>>> hdl/sgi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_back
// Quotient clamp, floor rounding, base add, 48-bit saturation and the
// output register.
// ----------------------------------------------------------------------------
module sgi_back #(
    parameter int FRAC_BITS = sgi_pkg::FRAC_BITS_DEF,
    parameter int NW        = 68,
    parameter int DW        = 35
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  sgi_pkg::sgi_side_t  in_side,
    input  logic [NW-1:0]       in_q_x,
    input  logic [NW-1:0]       in_q_y,
    input  logic [DW-1:0]       in_rem_x,
    input  logic [DW-1:0]       in_rem_y,
    output logic                out_valid,
    output sgi_pkg::sgi_out_t   out_data
);
    import sgi_pkg::*;

    localparam int QW = (NW > 64) ? NW : 64;
    localparam int SW = 66;
    localparam logic [QW-1:0]        QCAP = QW'(1) << 62;
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (OUT_W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    // returns {saturated, value}
    function automatic logic [OUT_W:0] fin(
        input logic signed [COORD_MAX-1:0] base,
        input logic [NW-1:0]               q,
        input logic [DW-1:0]               rem,
        input logic                        neg
    );
        logic [QW-1:0]        qe;
        logic                 big;
        logic [63:0]          qc;
        logic                 rnz;
        logic signed [SW-1:0] bw;
        logic signed [SW-1:0] off;
        logic signed [SW-1:0] total;
        qe  = QW'(q);
        big = (qe > QCAP);
        qc  = big ? 64'(QCAP) : {1'b0, qe[62:0]};
        rnz = !big && (rem != '0);
        bw  = base;
        bw  = bw <<< FRAC_BITS;
        off = neg ? -$signed(SW'(qc + 64'(rnz))) : $signed(SW'(qc));
        total = bw + off;
        if (total > MAXV) begin
            return {1'b1, MAXV[OUT_W-1:0]};
        end else if (total < MINV) begin
            return {1'b1, MINV[OUT_W-1:0]};
        end else begin
            return {1'b0, total[OUT_W-1:0]};
        end
    endfunction

    logic [OUT_W:0] fx, fy;
    logic           valid_reg;
    sgi_out_t       data_reg;
    sgi_out_t       data_next;

    assign fx = fin(in_side.ax, in_q_x, in_rem_x, in_side.neg_x);
    assign fy = fin(in_side.ay, in_q_y, in_rem_y, in_side.neg_y);

    always_comb begin
        if (in_side.is_par) begin
            data_next = '0;
            data_next.status = ST_PARALLEL;
        end else begin
            data_next.status    = in_side.on_both ? ST_WITHIN : ST_OUTSIDE;
            data_next.x_out     = fx[OUT_W-1:0];
            data_next.y_out     = fy[OUT_W-1:0];
            data_next.saturated = fx[OUT_W] | fy[OUT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams segment pairs through segment_intersection under random valid and
// ready gaps and compares every result beat against an exact predictor of
// the crossing point, the within-both-segments test and saturation.
// ----------------------------------------------------------------------------

class isect_scoreboard;
    sgi_pkg::sgi_out_t pending[$];
    int unsigned       n_errors;

    // floor(2^16 * (base + rc*tn/det)), clamped to 48 bits
    static function logic signed [47:0] crossing_coord(longint base, longint rc,
                                                       longint tn, longint det,
                                                       inout bit sat);
        logic signed [127:0] num, q, r, total;
        logic signed [127:0] maxv, minv;
        maxv = (128'sd1 <<< 47) - 1;
        minv = -(128'sd1 <<< 47);
        num = (128'(signed'(rc)) * 128'(signed'(tn))) <<< 16;
        q = num / 128'(signed'(det));
        r = num % 128'(signed'(det));
        if (r != 0 && ((r < 0) != (det < 0))) q = q - 1;
        // the model clamps the quotient magnitude at 2^62 before adding base
        if (q > (128'sd1 <<< 62)) q = 128'sd1 <<< 62;
        if (q < -(128'sd1 <<< 62)) q = -(128'sd1 <<< 62);
        total = (128'(signed'(base)) <<< 16) + q;
        if (total > maxv) begin
            sat = 1;
            return maxv[47:0];
        end
        if (total < minv) begin
            sat = 1;
            return minv[47:0];
        end
        return total[47:0];
    endfunction

    function void note_pair(sgi_pkg::sgi_in_t p);
        longint ax, ay, rx, ry, sx, sy, qx, qy, det, tn, un;
        sgi_pkg::sgi_out_t e;
        bit sat;
        ax = p.ax; ay = p.ay;
        rx = longint'(p.bx) - ax; ry = longint'(p.by_coord) - ay;
        sx = longint'(p.dx) - longint'(p.cx); sy = longint'(p.dy) - longint'(p.cy);
        qx = longint'(p.cx) - ax; qy = longint'(p.cy) - ay;
        det = rx * sy - ry * sx;
        e = '0;
        if (det == 0) begin
            e.status = sgi_pkg::ST_PARALLEL;
        end else begin
            sat = 0;
            tn = qx * sy - qy * sx;
            un = qx * ry - qy * rx;
            e.x_out = crossing_coord(ax, rx, tn, det, sat);
            e.y_out = crossing_coord(ay, ry, tn, det, sat);
            e.saturated = sat;
            if (det < 0) begin
                det = -det; tn = -tn; un = -un;
            end
            e.status = (tn >= 0 && tn <= det && un >= 0 && un <= det)
                       ? sgi_pkg::ST_WITHIN : sgi_pkg::ST_OUTSIDE;
        end
        pending.push_back(e);
    endfunction

    function void check_result(sgi_pkg::sgi_out_t got);
        sgi_pkg::sgi_out_t e;
        if (pending.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected result beat %p", got);
            return;
        end
        e = pending.pop_front();
        if (got.status !== e.status || got.x_out !== e.x_out ||
            got.y_out !== e.y_out || got.saturated !== e.saturated) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p, got %p", e, got);
        end
    endfunction
endclass

module testbench;
    import sgi_pkg::*;

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    sgi_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready = 0;
    sgi_out_t m_payload;

    int       src_idle_pct = 7;
    int       sink_idle_pct = 55;
    int       hold_cycles = 0;
    int       cycle_count = 0;
    bit       src_done = 0;

    isect_scoreboard sb = new();

    segment_intersection u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_payload,
        .m_valid, .m_ready, .m_payload
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver side: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_payload);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(20)) - 10);
            3: return 16'(signed'($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pair(sgi_in_t p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 20) gap++;
        // idle cycles go before the beat; valid stays up between back-to-back beats
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_payload <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pair(p);
    endtask

    function automatic sgi_in_t random_pair();
        sgi_in_t p;
        int k;
        k = $urandom_range(9);
        p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        if (k == 0) begin
            // parallel: CD is AB shifted
            p.cx = p.ax + 16'sd3; p.cy = p.ay - 16'sd5;
            p.dx = p.bx + 16'sd3; p.dy = p.by_coord - 16'sd5;
        end else if (k == 1) begin
            // shared end point
            p.cx = p.bx; p.cy = p.by_coord;
        end
        return p;
    endfunction

    initial begin
        sgi_in_t dir[$];
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        dir.push_back({16'sd0, 16'sd0, 16'sd4, 16'sd4, 16'sd0, 16'sd4, 16'sd4, 16'sd0});
        dir.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd5, 16'sd0, 16'sd6, -16'sd1});
        dir.push_back({16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd1});
        dir.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd1});
        dir.push_back({16'sd3, -16'sd5, 16'sd3, 16'sd9, -16'sd2, 16'sd0, 16'sd7, 16'sd0});
        dir.push_back({16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd2, 16'sd0, 16'sd2, 16'sd5});
        dir.push_back({16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, 16'sd1, 16'sd3, 16'sd0});
        dir.push_back({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                       16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        // nearly parallel long lines that meet at their shared end point
        dir.push_back({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                       16'sh8000, 16'sh8001, 16'sh7fff, 16'sh7fff});
        dir.push_back({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                       16'sh7fff, 16'sh8001, 16'sh8000, 16'sh7fff});
        dir.push_back({-16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1});
        dir.push_back({16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7fff,
                       16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001});
        foreach (dir[i]) send_pair(dir[i]);

        repeat (600) send_pair(random_pair());

        // long receiver hold-off while the sender keeps offering
        hold_cycles <= 300;
        src_idle_pct = 55;
        sink_idle_pct = 7;
        repeat (550) send_pair(random_pair());

        src_idle_pct = 0;
        sink_idle_pct = 0;
        repeat (550) send_pair(random_pair());
        s_valid <= 0;
        src_done = 1;
    end

    initial begin
        wait (src_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> segment_intersection.f
hdl/sgi_pkg.sv
hdl/sgi_front.sv
hdl/sgi_div_stage.sv
hdl/sgi_back.sv
hdl/segment_intersection.sv
verif/testbench.sv
